[design/bsa_pkg.sv]
// shared types and constants of the bitmap slot allocator
package bsa_pkg;

  localparam int SLOT_COUNT_W   = 11;
  localparam int OBJ_BYTES_W    = 17;
  localparam int REQ_W          = 2;
  localparam int SLOT_W         = 10;
  localparam int STATUS_W       = 2;
  localparam int OFFSET_W       = 26;
  localparam int CFG_DATA_W     = 17;
  localparam int CFG_IDX_W      = 1;

  localparam int DEF_MAX_SLOTS  = 1024;
  localparam int DEF_WORD_BITS  = 64;
  localparam int SLOT_COUNT_RST = 1024;
  localparam int OBJ_BYTES_RST  = 256;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_REINIT = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_ALLOC = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_COUNT = 1'b0,
    CFG_OBJ_BYTES  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_FIND,
    S_FCHK
  } state_t;

  typedef struct packed {
    logic [SLOT_COUNT_W-1:0] slot_count;
    logic [OBJ_BYTES_W-1:0]  object_bytes;
  } cfg_t;

  typedef struct packed {
    logic                strobe;
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic                full;
  } res_t;

endpackage

[design/bsa_map_ram.sv]
// used-slot bitmap memory, one write port and one registered read port
module bsa_map_ram #(
  parameter int WIDTH = bsa_pkg::DEF_WORD_BITS,
  parameter int DEPTH = bsa_pkg::DEF_MAX_SLOTS / bsa_pkg::DEF_WORD_BITS
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/bsa_ctrl.sv]
// allocator sequencer: map sweep, first-fit scan, free check and offset multiply
module bsa_ctrl #(
  parameter int MAX_SLOTS = bsa_pkg::DEF_MAX_SLOTS,
  parameter int WORD_BITS = bsa_pkg::DEF_WORD_BITS,
  parameter int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS,
  parameter int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bsa_pkg::REQ_W-1:0]     req_type,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_in,
  input  bsa_pkg::cfg_t                 cfg,
  output bsa_pkg::res_t                 res,
  output logic                          map_we,
  output logic [ADDR_W-1:0]             map_waddr,
  output logic [WORD_BITS-1:0]          map_wdata,
  output logic [ADDR_W-1:0]             map_raddr,
  input  logic [WORD_BITS-1:0]          map_rdata
);

  localparam int TOTAL   = MAP_WORDS * WORD_BITS;
  localparam int IDX_W   = $clog2(TOTAL + 1);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int CMP_W   = (IDX_W > bsa_pkg::SLOT_COUNT_W) ? IDX_W : bsa_pkg::SLOT_COUNT_W;
  localparam int PROD_W  = IDX_W + bsa_pkg::OBJ_BYTES_W;
  localparam int RST_EFF = (bsa_pkg::SLOT_COUNT_RST > MAX_SLOTS) ? MAX_SLOTS
                                                                 : bsa_pkg::SLOT_COUNT_RST;

  bsa_pkg::state_t      state_r, state_nxt;
  logic [ADDR_W-1:0]    w_r, w_nxt;
  logic [IDX_W-1:0]     base_r, base_nxt;
  logic [IDX_W-1:0]     cnt_lat_r, cnt_lat_nxt;
  logic [IDX_W-1:0]     used_cnt_r, used_cnt_nxt;
  logic                 resp_pend_r, resp_pend_nxt;
  logic [IDX_W-1:0]     sel_r, sel_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [IDX_W-1:0]     gnt_slot_r, gnt_slot_nxt;
  bsa_pkg::res_t        res_r, res_nxt;

  logic [CMP_W-1:0]     eff_live;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     sel_ext;
  logic [WORD_BITS-1:0] init_word;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     low_bit;
  logic [PROD_W-1:0]    prod;
  logic                 is_full;
  logic                 last_word;

  assign cnt_ext   = CMP_W'(cfg.slot_count);
  assign eff_live  = (cnt_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : cnt_ext;
  assign sel_ext   = CMP_W'(slot_in);
  assign free_bits = ~map_rdata;
  assign is_full   = (used_cnt_r == IDX_W'(TOTAL));
  assign last_word = (w_r == ADDR_W'(MAP_WORDS - 1));
  assign prod      = PROD_W'(gnt_slot_r) * PROD_W'(cfg.object_bytes);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      init_word[b] = (base_r + IDX_W'(b)) >= cnt_lat_r;
    end
  end

  always_comb begin
    low_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        low_bit = BIT_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsa_pkg::S_SWEEP;
      w_r         <= '0;
      base_r      <= '0;
      cnt_lat_r   <= IDX_W'(RST_EFF);
      used_cnt_r  <= '0;
      resp_pend_r <= 1'b0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      base_r      <= base_nxt;
      cnt_lat_r   <= cnt_lat_nxt;
      used_cnt_r  <= used_cnt_nxt;
      resp_pend_r <= resp_pend_nxt;
      res_r       <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r        <= sel_nxt;
    bit_r        <= bit_nxt;
    gnt_slot_r   <= gnt_slot_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    cnt_lat_nxt   = cnt_lat_r;
    used_cnt_nxt  = used_cnt_r;
    resp_pend_nxt = resp_pend_r;
    sel_nxt       = sel_r;
    bit_nxt       = bit_r;
    gnt_slot_nxt  = gnt_slot_r;
    res_nxt       = res_r;
    res_nxt.strobe = 1'b0;
    map_we        = 1'b0;
    map_waddr     = w_r;
    map_wdata     = init_word;
    map_raddr     = w_r;

    unique case (state_r)
      bsa_pkg::S_SWEEP: begin
        map_we = 1'b1;
        if (last_word) begin
          used_cnt_nxt  = IDX_W'(TOTAL) - cnt_lat_r;
          resp_pend_nxt = 1'b0;
          state_nxt     = bsa_pkg::S_IDLE;
          if (resp_pend_r) begin
            res_nxt.strobe = 1'b1;
            res_nxt.status = bsa_pkg::STAT_OK;
            res_nxt.slot   = '0;
            res_nxt.offset = '0;
            res_nxt.full   = (cnt_lat_r == '0);
          end
        end else begin
          w_nxt    = w_r + ADDR_W'(1);
          base_nxt = IDX_W'(base_r + IDX_W'(WORD_BITS));
        end
      end

      bsa_pkg::S_IDLE: begin
        map_raddr = '0;
        if (start) begin
          res_nxt.slot   = '0;
          res_nxt.offset = '0;
          res_nxt.full   = is_full;
          res_nxt.status = bsa_pkg::STAT_OK;
          w_nxt          = '0;
          base_nxt       = '0;
          unique case (bsa_pkg::req_t'(req_type))
            bsa_pkg::REQ_ALLOC: begin
              if (is_full) begin
                res_nxt.strobe = 1'b1;
                res_nxt.status = bsa_pkg::STAT_FULL;
              end else begin
                state_nxt = bsa_pkg::S_SCAN;
              end
            end
            bsa_pkg::REQ_FREE: begin
              if (sel_ext >= eff_live) begin
                res_nxt.strobe = 1'b1;
                res_nxt.status = bsa_pkg::STAT_RANGE;
              end else begin
                sel_nxt   = IDX_W'(sel_ext);
                state_nxt = bsa_pkg::S_FIND;
              end
            end
            bsa_pkg::REQ_REINIT: begin
              cnt_lat_nxt   = IDX_W'(eff_live);
              resp_pend_nxt = 1'b1;
              state_nxt     = bsa_pkg::S_SWEEP;
            end
            bsa_pkg::REQ_NOP: begin
              res_nxt.strobe = 1'b1;
            end
          endcase
        end
      end

      bsa_pkg::S_SCAN: begin
        map_raddr = w_r + ADDR_W'(1);
        if (free_bits != '0) begin
          map_we       = 1'b1;
          map_wdata    = map_rdata | (WORD_BITS'(1) << low_bit);
          gnt_slot_nxt = IDX_W'(base_r + IDX_W'(low_bit));
          used_cnt_nxt = used_cnt_r + IDX_W'(1);
          state_nxt    = bsa_pkg::S_MUL;
        end else if (last_word) begin
          res_nxt.strobe = 1'b1;
          res_nxt.status = bsa_pkg::STAT_FULL;
          state_nxt      = bsa_pkg::S_IDLE;
        end else begin
          w_nxt    = w_r + ADDR_W'(1);
          base_nxt = IDX_W'(base_r + IDX_W'(WORD_BITS));
        end
      end

      bsa_pkg::S_MUL: begin
        res_nxt.strobe = 1'b1;
        res_nxt.status = bsa_pkg::STAT_OK;
        res_nxt.slot   = bsa_pkg::SLOT_W'(gnt_slot_r);
        res_nxt.offset = bsa_pkg::OFFSET_W'(prod);
        res_nxt.full   = is_full;
        state_nxt      = bsa_pkg::S_IDLE;
      end

      bsa_pkg::S_FIND: begin
        if (sel_r < IDX_W'(base_r + IDX_W'(WORD_BITS))) begin
          bit_nxt   = BIT_W'(sel_r - base_r);
          state_nxt = bsa_pkg::S_FCHK;
        end else begin
          w_nxt    = w_r + ADDR_W'(1);
          base_nxt = IDX_W'(base_r + IDX_W'(WORD_BITS));
        end
      end

      bsa_pkg::S_FCHK: begin
        res_nxt.strobe = 1'b1;
        state_nxt      = bsa_pkg::S_IDLE;
        if (map_rdata[bit_r]) begin
          map_we         = 1'b1;
          map_wdata      = map_rdata & ~(WORD_BITS'(1) << bit_r);
          used_cnt_nxt   = used_cnt_r - IDX_W'(1);
          res_nxt.status = bsa_pkg::STAT_OK;
          res_nxt.full   = 1'b0;
        end else begin
          res_nxt.status = bsa_pkg::STAT_NOT_ALLOC;
          res_nxt.full   = is_full;
        end
      end

      default: begin
        state_nxt = bsa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != bsa_pkg::S_IDLE);
  assign res  = res_r;

endmodule

[design/bitmap_slot_allocator_top.sv]
// top level of the bitmap first-fit slot allocator with its configuration registers
//
// An item is taken when start is high and busy is low; its one result appears on
// the out_ ports for a single cycle with out_strobe high and must be captured then,
// since the block cannot be held off. The map is kept in a memory of MAP_WORDS words
// read one word per cycle. An allocate scans from word 0 to the first word with a
// free slot, marks that slot and then forms the byte offset; a free steps to the
// word of its slot, then checks and clears its bit; a reinitialize rewrites every
// word; an allocate on a full pool, a free out of range or a no-op is answered from
// idle without reading the map. After reset the map is rewritten over all MAP_WORDS
// words (16 for the default pool) while busy is high; configuration writes are taken
// at any time and a new slot_count reaches the map at the next reinitialize.
module bitmap_slot_allocator_top #(
  parameter int MAX_SLOTS = bsa_pkg::DEF_MAX_SLOTS,
  parameter int WORD_BITS = bsa_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bsa_pkg::REQ_W-1:0]       in_req_type,
  input  logic [bsa_pkg::SLOT_W-1:0]      in_slot_in,
  output logic                            out_strobe,
  output logic [bsa_pkg::STATUS_W-1:0]    out_status,
  output logic [bsa_pkg::SLOT_W-1:0]      out_slot_out,
  output logic [bsa_pkg::OFFSET_W-1:0]    out_byte_offset,
  output logic                            out_pool_full,
  input  logic                            cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  bsa_pkg::cfg_t        cfg_r, cfg_nxt;
  bsa_pkg::res_t        res;
  logic                 map_we;
  logic [ADDR_W-1:0]    map_waddr;
  logic [WORD_BITS-1:0] map_wdata;
  logic [ADDR_W-1:0]    map_raddr;
  logic [WORD_BITS-1:0] map_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_count   <= bsa_pkg::SLOT_COUNT_W'(bsa_pkg::SLOT_COUNT_RST);
      cfg_r.object_bytes <= bsa_pkg::OBJ_BYTES_W'(bsa_pkg::OBJ_BYTES_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (bsa_pkg::cfg_idx_t'(cfg_index))
        bsa_pkg::CFG_SLOT_COUNT: cfg_nxt.slot_count   = cfg_wdata[bsa_pkg::SLOT_COUNT_W-1:0];
        bsa_pkg::CFG_OBJ_BYTES:  cfg_nxt.object_bytes = cfg_wdata[bsa_pkg::OBJ_BYTES_W-1:0];
      endcase
    end
  end

  bsa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (in_req_type),
    .slot_in   (in_slot_in),
    .cfg       (cfg_r),
    .res       (res),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata)
  );

  bsa_map_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign out_strobe      = res.strobe;
  assign out_status      = res.status;
  assign out_slot_out    = res.slot;
  assign out_byte_offset = res.offset;
  assign out_pool_full   = res.full;

endmodule
